// ===== hdl/cgvg_pkg.sv =====
// ----------------------------------------------------------------------------
// cgvg_pkg
// Shared types, widths and constants of the cone grid vertex generator.
// ----------------------------------------------------------------------------
package cgvg_pkg;

  // Register map of the configuration port
  typedef enum logic [7:0] {
    REG_CONE_RADIUS = 8'd0,
    REG_CONE_HEIGHT = 8'd1,
    REG_STACK_COUNT = 8'd2,
    REG_SLICE_COUNT = 8'd3
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned CNT_W  = 9;   // counts and grid indexes
  localparam int unsigned POS_W  = 24;  // signed Q8.16 positions
  localparam int unsigned IDX_W  = 17;  // vertex and corner indexes
  localparam int unsigned TEX_W  = 17;  // unsigned Q1.16 texture coordinates
  localparam int unsigned MAG_W  = 25;  // position magnitude before saturation
  localparam int unsigned FRAC_BITS = 16;  // texture fraction bits

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 160;
  localparam int unsigned OUT_USER_W = 2;

  // Long division: one quotient bit per stage
  localparam int unsigned DIV_NUM_W = 34;
  localparam int unsigned DIV_DEN_W = 10;
  localparam int unsigned DIV_LAT   = DIV_NUM_W;

  // Phase and trig
  localparam int unsigned PHASE_W     = 24;
  localparam int unsigned QUAD_SHIFT  = 22;
  localparam int unsigned TRIG_W      = 31;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int unsigned NUM_STEPS   = 6;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned TRIG_LAT    = 2 + 3 * NUM_STEPS;

  // Result flags in tuser
  localparam int unsigned USER_QUAD  = 0;
  localparam int unsigned USER_CLAMP = 1;

  // Horner divisors, innermost bracket first
  function automatic int unsigned sin_div(input int unsigned k);
    unique case (k)
      0:       sin_div = 110;
      1:       sin_div = 72;
      2:       sin_div = 42;
      3:       sin_div = 20;
      4:       sin_div = 6;
      default: sin_div = 1;
    endcase
  endfunction

  function automatic int unsigned cos_div(input int unsigned k);
    unique case (k)
      0:       cos_div = 132;
      1:       cos_div = 90;
      2:       cos_div = 56;
      3:       cos_div = 30;
      4:       cos_div = 12;
      default: cos_div = 2;
    endcase
  endfunction

  // Fields that ride beside the dividers
  typedef struct packed {
    logic             valid;
    logic             y_neg;
    logic             clamped;
    logic             quad_valid;
    logic [IDX_W-1:0] vertex_number;
    logic [IDX_W-1:0] lower;
    logic [IDX_W-1:0] upper;
  } side_t;

  // Fields that ride beside the trig unit
  typedef struct packed {
    side_t            side;
    logic [POS_W-1:0] radius;
    logic [1:0]       quadrant;
    logic [MAG_W-1:0] y_mag;
    logic [TEX_W-1:0] tex_s;
    logic [TEX_W-1:0] tex_t;
  } trig_side_t;

endpackage

// ===== hdl/cgvg_delay.sv =====
// ----------------------------------------------------------------------------
// cgvg_delay
// Enabled shift line that keeps side fields in step with a pipelined unit.
// ----------------------------------------------------------------------------
module cgvg_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned s = 0; s < DEPTH; s++) pipe_q[s] <= '0;
    end else if (en_i) begin
      pipe_q[0] <= d_i;
      for (int unsigned s = 1; s < DEPTH; s++) pipe_q[s] <= pipe_q[s-1];
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

// ===== hdl/cgvg_div.sv =====
// ----------------------------------------------------------------------------
// cgvg_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cgvg_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 10
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [NUM_W-1:0] num_w [NUM_W+1];
  logic [NUM_W-1:0] quo_w [NUM_W+1];
  logic [DEN_W-1:0] rem_w [NUM_W+1];
  logic [DEN_W-1:0] den_w [NUM_W+1];

  assign num_w[0] = num_i;
  assign quo_w[0] = '0;
  assign rem_w[0] = '0;
  assign den_w[0] = den_i;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W-1:0] rem_d, rem_q, den_q;
    logic [NUM_W-1:0] quo_d, quo_q, num_q;

    always_comb begin
      rem_sh = {rem_w[s], num_w[s][NUM_W-1-s]};
      ge     = (rem_sh >= {1'b0, den_w[s]});
      rem_d  = ge ? DEN_W'(rem_sh - {1'b0, den_w[s]}) : rem_sh[DEN_W-1:0];
      quo_d  = quo_w[s];
      quo_d[NUM_W-1-s] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        num_q <= num_w[s];
        den_q <= den_w[s];
      end
    end

    assign rem_w[s+1] = rem_q;
    assign quo_w[s+1] = quo_q;
    assign num_w[s+1] = num_q;
    assign den_w[s+1] = den_q;
  end

  assign quo_o = quo_w[NUM_W];

endmodule

// ===== hdl/cgvg_trig.sv =====
// ----------------------------------------------------------------------------
// cgvg_trig
// Sine and cosine of a quarter-turn fraction, Horner series in Q30.
// ----------------------------------------------------------------------------
module cgvg_trig (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [21:0] frac_i,
  output logic [30:0] sin_o,
  output logic [30:0] cos_o
);
  import cgvg_pkg::*;

  logic [52:0] ang_prod;
  logic [30:0] x1_q, x2x_q;
  logic [61:0] sq_prod;
  logic [31:0] x2_q;

  // Scale the fraction to radians, then square
  assign ang_prod = 53'(frac_i) * 53'(HALF_PI_Q30);
  assign sq_prod  = 62'(x1_q) * 62'(x1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= ang_prod[QUAD_SHIFT +: TRIG_W];
      x2_q  <= sq_prod[61:30];
      x2x_q <= x1_q;
    end
  end

  logic [31:0] x2_w [NUM_STEPS+1];
  logic [30:0] x_w  [NUM_STEPS+1];
  logic [30:0] bc_w [NUM_STEPS+1];
  logic [30:0] bs_w [NUM_STEPS+1];

  assign x2_w[0] = x2_q;
  assign x_w[0]  = x2x_q;
  assign bc_w[0] = Q30_ONE;
  assign bs_w[0] = Q30_ONE;

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    localparam bit          SIN_TAIL = (k == NUM_STEPS - 1);
    localparam int unsigned DC = cos_div(k);
    localparam int unsigned DS = sin_div(k);
    localparam logic [31:0] MC = 32'((64'd1 << RECIP_SHIFT) / DC);
    localparam logic [31:0] MS = 32'((64'd1 << RECIP_SHIFT) / DS);

    logic [62:0] pc, ps;
    logic [31:0] tc_d, ts_d;
    logic [31:0] tc_q, ts_q, x2a_q;
    logic [30:0] xa_q;
    logic [63:0] rc, rs;
    logic [31:0] qc_q, qs_q, tcb_q, tsb_q, x2b_q;
    logic [30:0] xb_q;
    logic [39:0] mc, ms;
    logic [31:0] remc, rems, qc, qs;
    logic [30:0] bc_d, bs_d, bc_q, bs_q, xc_q;
    logic [31:0] x2c_q;

    // Stage a: multiply the bracket by x^2 (or by x for the last sine step)
    always_comb begin
      pc   = 63'(x2_w[k]) * 63'(bc_w[k]);
      tc_d = pc[61:30];
      if (SIN_TAIL) begin
        ps   = 63'(x_w[k]) * 63'(bs_w[k]);
        ts_d = (ps[61:30] > 32'(Q30_ONE)) ? 32'(Q30_ONE) : ps[61:30];
      end else begin
        ps   = 63'(x2_w[k]) * 63'(bs_w[k]);
        ts_d = ps[61:30];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tc_q  <= tc_d;
        ts_q  <= ts_d;
        x2a_q <= x2_w[k];
        xa_q  <= x_w[k];
      end
    end

    // Stage b: quotient estimate by reciprocal, low by at most one
    assign rc = 64'(tc_q) * 64'(MC);
    assign rs = 64'(ts_q) * 64'(MS);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qc_q  <= rc[RECIP_SHIFT +: 32];
        qs_q  <= SIN_TAIL ? ts_q : rs[RECIP_SHIFT +: 32];
        tcb_q <= tc_q;
        tsb_q <= ts_q;
        x2b_q <= x2a_q;
        xb_q  <= xa_q;
      end
    end

    // Stage c: correct the estimate, then one minus it, floored at zero (the last sine step passes its product)
    always_comb begin
      mc   = 40'(qc_q) * 40'(DC);
      ms   = 40'(qs_q) * 40'(DS);
      remc = tcb_q - mc[31:0];
      rems = tsb_q - ms[31:0];
      qc   = (remc >= 32'(DC)) ? qc_q + 32'd1 : qc_q;
      qs   = (rems >= 32'(DS)) ? qs_q + 32'd1 : qs_q;
      bc_d = (qc >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - qc);
      if (SIN_TAIL) bs_d = qs_q[30:0];
      else          bs_d = (qs >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - qs);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        bc_q  <= bc_d;
        bs_q  <= bs_d;
        x2c_q <= x2b_q;
        xc_q  <= xb_q;
      end
    end

    assign bc_w[k+1] = bc_q;
    assign bs_w[k+1] = bs_q;
    assign x2_w[k+1] = x2c_q;
    assign x_w[k+1]  = xc_q;
  end

  assign sin_o = bs_w[NUM_STEPS];
  assign cos_o = bc_w[NUM_STEPS];

endmodule

// ===== hdl/cone_grid_vertex_generator_unit.sv =====
// ----------------------------------------------------------------------------
// cone_grid_vertex_generator_unit
// Position, texture coordinate and mesh indexes of one cone grid point.
// ----------------------------------------------------------------------------
//
//  channel    direction  handshake                 payload
//  s_axis     in         s_axis_tvalid/tready      stack_index, slice_index
//  m_axis     out        m_axis_tvalid/tready      positions, texture, indexes
//                                                 + tuser flags
//  cfg        in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
//  One grid point enters per clock while the pipeline is not held. A result
//  passes through the 34-stage long divider (one quotient bit a stage) and
//  the 20-stage sine/cosine Horner pipeline behind it.
//  Reset loads the register defaults and clears every valid bit.
//  When the output register holds an untaken result, the whole pipeline
//  holds and s_axis_tready drops; nothing is dropped or repeated.
//
module cone_grid_vertex_generator_unit #(
  parameter int unsigned MAX_STACKS = 256,
  parameter int unsigned MAX_SLICES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Grid point in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [8:0] stack_index, [17:9] slice_index, [23:18] zero
  input  logic [cgvg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Vertex out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [23:0] pos_x, [47:24] pos_y, [71:48] pos_z, [88:72] tex_s, [105:89] tex_t,
  // [122:106] vertex_number, [139:123] quad_lower_corner,
  // [156:140] quad_upper_corner, [159:157] zero
  output logic [cgvg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] quad_valid, [1] index_clamped
  output logic [cgvg_pkg::OUT_USER_W-1:0] m_axis_tuser,
  // Register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cgvg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cgvg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import cgvg_pkg::*;

  // ---------------------------------------------------------------- config
  logic [POS_W-1:0] radius_q, height_q;
  logic [CNT_W-1:0] stacks_q, slices_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= POS_W'(65536);
      height_q <= POS_W'(65536);
      stacks_q <= CNT_W'(8);
      slices_q <= CNT_W'(16);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CONE_RADIUS: radius_q <= cfg_data_i[POS_W-1:0];
        REG_CONE_HEIGHT: height_q <= cfg_data_i[POS_W-1:0];
        REG_STACK_COUNT: stacks_q <= cfg_data_i[CNT_W-1:0];
        REG_SLICE_COUNT: slices_q <= cfg_data_i[CNT_W-1:0];
        default: ;  // drop writes beyond the register map
      endcase
    end
  end

  // Zero acts as one, above the maximum acts as the maximum
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v,
                                                 input int unsigned maxv);
    if (v == '0)                        eff_count = CNT_W'(1);
    else if (11'(v) > 11'(maxv))        eff_count = CNT_W'(maxv);
    else                                eff_count = v;
  endfunction

  // Saturate a sign and magnitude to 24 bit two's complement
  function automatic logic [POS_W-1:0] pack_pos(input logic neg,
                                                input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] m;
    m = mag;
    if (neg) begin
      if (m > MAG_W'(24'h80_0000)) m = MAG_W'(24'h80_0000);
      pack_pos = POS_W'(~m + MAG_W'(1));
    end else begin
      pack_pos = (m > MAG_W'(24'h7F_FFFF)) ? 24'h7F_FFFF : m[POS_W-1:0];
    end
  endfunction

  // Global advance: move when the output register is free or being taken
  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // ------------------------------------------------- stage A: clamp indexes
  logic [CNT_W-1:0] in_i, in_j, sc_w, sl_w;
  logic             a_valid_q, a_clamp_q;
  logic [CNT_W-1:0] a_i_q, a_j_q, a_sc_q, a_sl_q;

  assign in_i = s_axis_tdata[8:0];
  assign in_j = s_axis_tdata[17:9];
  assign sc_w = eff_count(stacks_q, MAX_STACKS);
  assign sl_w = eff_count(slices_q, MAX_SLICES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_valid_q <= 1'b0;
    else if (en) a_valid_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_i_q     <= (in_i > sc_w) ? sc_w : in_i;
      a_j_q     <= (in_j > sl_w) ? sl_w : in_j;
      a_clamp_q <= (in_i > sc_w) || (in_j > sl_w);
      a_sc_q    <= sc_w;
      a_sl_q    <= sl_w;
    end
  end

  // ---------------------------------------- stage B: numerators and indexes
  logic [DIV_NUM_W-1:0] r_num, p_num, y_num, ts_num, tt_num;
  logic [CNT_W:0]       two_i, y_abs;
  logic                 y_neg, quad;
  logic [18:0]          vnum_w;
  logic [IDX_W-1:0]     upper_w;

  always_comb begin
    r_num   = DIV_NUM_W'(radius_q) * DIV_NUM_W'(a_sc_q - a_i_q)
              + DIV_NUM_W'(a_sc_q >> 1);
    p_num   = (a_j_q >= a_sl_q) ? '0 :
              (DIV_NUM_W'(a_j_q) << PHASE_W) + DIV_NUM_W'(a_sl_q >> 1);
    two_i   = {a_i_q, 1'b0};
    y_neg   = (two_i < {1'b0, a_sc_q});
    y_abs   = y_neg ? ({1'b0, a_sc_q} - two_i) : (two_i - {1'b0, a_sc_q});
    y_num   = DIV_NUM_W'(height_q) * DIV_NUM_W'(y_abs) + DIV_NUM_W'(a_sc_q);
    ts_num  = (DIV_NUM_W'(a_j_q) << FRAC_BITS) + DIV_NUM_W'(a_sl_q >> 1);
    tt_num  = (DIV_NUM_W'(a_i_q) << FRAC_BITS) + DIV_NUM_W'(a_sc_q >> 1);
    vnum_w  = 19'(a_i_q) * (19'(a_sl_q) + 19'd1) + 19'(a_j_q);
    quad    = (a_i_q < a_sc_q) && (a_j_q < a_sl_q);
    upper_w = vnum_w[IDX_W-1:0] + IDX_W'(a_sl_q) + IDX_W'(2);
  end

  logic [DIV_NUM_W-1:0] b_r_num_q, b_p_num_q, b_y_num_q, b_ts_num_q, b_tt_num_q;
  logic [CNT_W-1:0]     b_sc_q, b_sl_q;
  side_t                b_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_side_q <= '0;
    end else if (en) begin
      b_side_q.valid           <= a_valid_q;
      b_side_q.y_neg           <= y_neg;
      b_side_q.clamped         <= a_clamp_q;
      b_side_q.quad_valid      <= quad;
      b_side_q.vertex_number   <= vnum_w[IDX_W-1:0];
      b_side_q.lower           <= quad ? vnum_w[IDX_W-1:0] : '0;
      b_side_q.upper           <= quad ? upper_w : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_r_num_q                <= r_num;
      b_p_num_q                <= p_num;
      b_y_num_q                <= y_num;
      b_ts_num_q               <= ts_num;
      b_tt_num_q               <= tt_num;
      b_sc_q                   <= a_sc_q;
      b_sl_q                   <= a_sl_q;
    end
  end

  // ---------------------------------------------------- dividers
  logic [DIV_NUM_W-1:0] r_quo, p_quo, y_quo, ts_quo, tt_quo;
  side_t                d_side;

  cgvg_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_radius (
    .clk_i, .en_i(en), .num_i(b_r_num_q), .den_i(DIV_DEN_W'(b_sc_q)), .quo_o(r_quo)
  );
  cgvg_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_phase (
    .clk_i, .en_i(en), .num_i(b_p_num_q), .den_i(DIV_DEN_W'(b_sl_q)), .quo_o(p_quo)
  );
  cgvg_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_height (
    .clk_i, .en_i(en), .num_i(b_y_num_q), .den_i({b_sc_q, 1'b0}), .quo_o(y_quo)
  );
  cgvg_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_tex_s (
    .clk_i, .en_i(en), .num_i(b_ts_num_q), .den_i(DIV_DEN_W'(b_sl_q)), .quo_o(ts_quo)
  );
  cgvg_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div_tex_t (
    .clk_i, .en_i(en), .num_i(b_tt_num_q), .den_i(DIV_DEN_W'(b_sc_q)), .quo_o(tt_quo)
  );

  cgvg_delay #(.W($bits(side_t)), .DEPTH(DIV_LAT)) u_side_div (
    .clk_i, .rst_ni, .en_i(en), .d_i(b_side_q), .q_o(d_side)
  );

  // ---------------------------------------------------- trig
  logic [TRIG_W-1:0] sin_w, cos_w;
  trig_side_t        t_in, t_side;

  cgvg_trig u_trig (
    .clk_i, .en_i(en), .frac_i(p_quo[QUAD_SHIFT-1:0]), .sin_o(sin_w), .cos_o(cos_w)
  );

  always_comb begin
    t_in.side     = d_side;
    t_in.radius   = r_quo[POS_W-1:0];
    t_in.quadrant = p_quo[PHASE_W-1:QUAD_SHIFT];
    t_in.y_mag    = y_quo[MAG_W-1:0];
    t_in.tex_s    = ts_quo[TEX_W-1:0];
    t_in.tex_t    = tt_quo[TEX_W-1:0];
  end

  cgvg_delay #(.W($bits(trig_side_t)), .DEPTH(TRIG_LAT)) u_side_trig (
    .clk_i, .rst_ni, .en_i(en), .d_i(t_in), .q_o(t_side)
  );

  // ----------------------------------- stage M: fold quadrant, scale by r
  logic [TRIG_W-1:0] sm, cm;
  logic              sneg, cneg;
  logic [55:0]       px, pz;

  always_comb begin
    unique case (t_side.quadrant)
      2'd0:    begin sm = sin_w; sneg = 1'b0; cm = cos_w; cneg = 1'b0; end
      2'd1:    begin sm = cos_w; sneg = 1'b0; cm = sin_w; cneg = 1'b1; end
      2'd2:    begin sm = sin_w; sneg = 1'b1; cm = cos_w; cneg = 1'b1; end
      default: begin sm = cos_w; sneg = 1'b1; cm = sin_w; cneg = 1'b0; end
    endcase
    // round half away from zero on the magnitude
    px = 56'(t_side.radius) * 56'(sm) + (56'(1) << 29);
    pz = 56'(t_side.radius) * 56'(cm) + (56'(1) << 29);
  end

  logic             m_valid_q, m_xneg_q, m_zneg_q;
  logic [MAG_W-1:0] m_xmag_q, m_zmag_q;
  trig_side_t       m_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else if (en) m_valid_q <= t_side.side.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_xmag_q <= px[30 +: MAG_W];
      m_zmag_q <= pz[30 +: MAG_W];
      m_xneg_q <= !sneg && (sm != '0);  // x is minus r*sin
      m_zneg_q <= cneg && (cm != '0);
      m_side_q <= t_side;
    end
  end

  // ---------------------------------------------------- output register
  logic [POS_W-1:0] o_x_q, o_y_q, o_z_q;
  logic [TEX_W-1:0] o_ts_q, o_tt_q;
  logic [IDX_W-1:0] o_vn_q, o_lo_q, o_up_q;
  logic             o_quad_q, o_clamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= m_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_x_q     <= pack_pos(m_xneg_q, m_xmag_q);
      o_z_q     <= pack_pos(m_zneg_q, m_zmag_q);
      o_y_q     <= pack_pos(m_side_q.side.y_neg && (m_side_q.y_mag != '0),
                            m_side_q.y_mag);
      o_ts_q    <= m_side_q.tex_s;
      o_tt_q    <= m_side_q.tex_t;
      o_vn_q    <= m_side_q.side.vertex_number;
      o_lo_q    <= m_side_q.side.lower;
      o_up_q    <= m_side_q.side.upper;
      o_quad_q  <= m_side_q.side.quad_valid;
      o_clamp_q <= m_side_q.side.clamped;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, o_up_q, o_lo_q, o_vn_q, o_tt_q, o_ts_q,
                          o_z_q, o_y_q, o_x_q};
  always_comb begin
    m_axis_tuser             = '0;
    m_axis_tuser[USER_QUAD]  = o_quad_q;
    m_axis_tuser[USER_CLAMP] = o_clamp_q;
  end

endmodule

// ===== hdl/cgvg_checker.sv =====
// ----------------------------------------------------------------------------
// cgvg_checker
// Port-level checks on the vertex output stream.
// ----------------------------------------------------------------------------
module cgvg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cgvg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [cgvg_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import cgvg_pkg::*;

  // No result may appear in the cycle after reset was seen
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Corners are zero unless the point starts a quad
  a_no_quad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[USER_QUAD] |-> m_axis_tdata[156:123] == '0)
    else $error("corners set on a point without a quad");

  // The lower corner is the point itself
  a_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[USER_QUAD]
      |-> m_axis_tdata[139:123] == m_axis_tdata[122:106])
    else $error("lower corner differs from vertex number");

endmodule

bind cone_grid_vertex_generator_unit cgvg_checker u_cgvg_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cone grid vertex generator: a local
// fixed-point predictor computes each vertex, and a checker compares every
// output transfer field by field against the oldest predicted vertex.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cgvg_pkg::*;

  localparam int unsigned LATENCY   = 58;
  localparam int unsigned WDOG_MAX  = 20000;
  localparam logic [63:0] Q30       = 64'h4000_0000;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [TEX_W-1:0] tex_s;
    logic [TEX_W-1:0] tex_t;
    logic [IDX_W-1:0] vnum;
    logic             quad_valid;
    logic [IDX_W-1:0] lower;
    logic [IDX_W-1:0] upper;
    logic             clamped;
  } vertex_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Shadow copy of the block's registers
  logic [23:0] radius_q;
  logic [23:0] height_q;
  logic [8:0]  stacks_q;
  logic [8:0]  slices_q;

  vertex_t     pending_vertices[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  cone_grid_vertex_generator_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [63:0] trig_q30(input logic [63:0] x, input bit want_sin);
    logic [63:0] x2, br;
    int          k, n;
    int unsigned d;
    x2 = (x * x) >> 30;
    br = Q30;
    n  = want_sin ? 5 : 6;
    for (k = 0; k < n; k++) begin
      d  = want_sin ? ((k == 0) ? 110 : (k == 1) ? 72 : (k == 2) ? 42 : (k == 3) ? 20 : 6)
                    : ((k == 0) ? 132 : (k == 1) ? 90 : (k == 2) ? 56 : (k == 3) ? 30
                       : (k == 4) ? 12 : 2);
      br = ((x2 * br) >> 30) / d;
      br = (br >= Q30) ? 64'd0 : Q30 - br;
    end
    if (want_sin) begin
      br = (x * br) >> 30;
      if (br > Q30) br = Q30;
    end
    return br;
  endfunction

  function automatic logic [POS_W-1:0] saturate_pos(input bit neg, input logic [63:0] mag);
    if (neg) begin
      if (mag > 64'd8388608) mag = 64'd8388608;
      return POS_W'(64'h100_0000 - mag);
    end
    return (mag > 64'd8388607) ? POS_W'(8388607) : POS_W'(mag);
  endfunction

  function automatic vertex_t predict_vertex(input logic [8:0] stack_in,
                                             input logic [8:0] slice_in);
    vertex_t     v;
    logic [63:0] sc, sl, i, j, r, p, u, x, s0, c0, sm, cm, ymag, vn;
    logic [1:0]  q;
    bit          sneg, cneg;
    sc = (stacks_q == 0) ? 1 : (stacks_q > 256) ? 256 : stacks_q;
    sl = (slices_q == 0) ? 1 : (slices_q > 256) ? 256 : slices_q;
    i  = stack_in;
    j  = slice_in;
    v.clamped = 1'b0;
    if (i > sc) begin i = sc; v.clamped = 1'b1; end
    if (j > sl) begin j = sl; v.clamped = 1'b1; end
    r = (radius_q * (sc - i) + sc / 2) / sc;
    p = (j >= sl) ? 64'd0 : (((j << 24) + sl / 2) / sl);
    p = p & 64'hFF_FFFF;
    q = p[23:22];
    u = p & 64'h3F_FFFF;
    x = (u * 64'd1686629713) >> 22;
    s0 = trig_q30(x, 1'b1);
    c0 = trig_q30(x, 1'b0);
    case (q)
      2'd0: begin sm = s0; sneg = 0; cm = c0; cneg = 0; end
      2'd1: begin sm = c0; sneg = 0; cm = s0; cneg = 1; end
      2'd2: begin sm = s0; sneg = 1; cm = c0; cneg = 1; end
      default: begin sm = c0; sneg = 1; cm = s0; cneg = 0; end
    endcase
    // x is minus r*sin, so it is negative when the sine is positive
    v.pos_x = saturate_pos(!sneg && sm != 0, (r * sm + (64'd1 << 29)) >> 30);
    v.pos_z = saturate_pos(cneg && cm != 0, (r * cm + (64'd1 << 29)) >> 30);
    if (2 * i < sc) begin
      ymag = (height_q * (sc - 2 * i) + sc) / (2 * sc);
      v.pos_y = saturate_pos(ymag != 0, ymag);
    end else begin
      ymag = (height_q * (2 * i - sc) + sc) / (2 * sc);
      v.pos_y = saturate_pos(1'b0, ymag);
    end
    v.tex_s = TEX_W'(((j << 16) + sl / 2) / sl);
    v.tex_t = TEX_W'(((i << 16) + sc / 2) / sc);
    vn = i * (sl + 1) + j;
    v.vnum = IDX_W'(vn);
    v.quad_valid = (i < sc) && (j < sl);
    v.lower = v.quad_valid ? IDX_W'(vn) : '0;
    v.upper = v.quad_valid ? IDX_W'(vn + sl + 2) : '0;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Checker: compare each output transfer with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_vertices.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex, expected none, actual 0x%0h", $time, m_axis_tdata);
      end else begin
        e = pending_vertices.pop_front();
        compare_field("pos_x", e.pos_x, m_axis_tdata[23:0]);
        compare_field("pos_y", e.pos_y, m_axis_tdata[47:24]);
        compare_field("pos_z", e.pos_z, m_axis_tdata[71:48]);
        compare_field("tex_s", e.tex_s, m_axis_tdata[88:72]);
        compare_field("tex_t", e.tex_t, m_axis_tdata[105:89]);
        compare_field("vertex_number", e.vnum, m_axis_tdata[122:106]);
        compare_field("quad_lower_corner", e.lower, m_axis_tdata[139:123]);
        compare_field("quad_upper_corner", e.upper, m_axis_tdata[156:140]);
        compare_field("quad_valid", e.quad_valid, m_axis_tuser[USER_QUAD]);
        compare_field("index_clamped", e.clamped, m_axis_tuser[USER_CLAMP]);
      end
    end
  end

  // Random receiver stalls, changed at the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Leave tvalid high after the transfer so that a following point goes
  // back to back; idle cycles and the drain drop it.
  task automatic send_point(input logic [8:0] stack_in, input logic [8:0] slice_in);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, slice_in, stack_in};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_vertices.push_back(predict_vertex(stack_in, slice_in));
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [23:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_CONE_RADIUS: radius_q = value;
      REG_CONE_HEIGHT: height_q = value;
      REG_STACK_COUNT: stacks_q = value[8:0];
      REG_SLICE_COUNT: slices_q = value[8:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_geometry(input logic [23:0] rad, input logic [23:0] hgt,
                              input logic [23:0] stk, input logic [23:0] slc);
    drain_pipeline();
    write_register(REG_CONE_RADIUS, rad);
    write_register(REG_CONE_HEIGHT, hgt);
    write_register(REG_STACK_COUNT, stk);
    write_register(REG_SLICE_COUNT, slc);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_points();
    // Reset geometry: base, apex, seam, quadrants, clamping on both indexes
    send_point(0, 0);
    send_point(0, 4);
    send_point(0, 8);
    send_point(0, 12);
    send_point(0, 16);
    send_point(8, 16);
    send_point(4, 3);
    send_point(9'h1FF, 9'h1FF);
    send_point(20, 2);
    send_point(3, 300);
    send_point(7, 15);
    send_point(8, 0);
    // Extremes: largest radius and height force position saturation
    set_geometry(24'hFFFFFF, 24'hFFFFFF, 256, 256);
    send_point(0, 0);
    send_point(0, 64);
    send_point(0, 128);
    send_point(0, 192);
    send_point(256, 256);
    send_point(255, 255);
    send_point(0, 37);
    // Zero counts act as one, oversize counts act as the maximum
    set_geometry(0, 0, 0, 9'h1FF);
    send_point(0, 0);
    send_point(1, 256);
    send_point(2, 511);
    send_point(0, 100);
  endtask

  task automatic run_random_phase(input int unsigned n_items);
    logic [8:0] a, b;
    int unsigned mode;
    repeat (n_items) begin
      mode = $urandom_range(9);
      // Mostly in-grid points; some right at the edge and some far outside
      a = (mode < 7) ? 9'($urandom_range(stacks_q == 0 ? 1 : stacks_q))
                     : (mode < 9) ? 9'($urandom) : stacks_q;
      mode = $urandom_range(9);
      b = (mode < 7) ? 9'($urandom_range(slices_q == 0 ? 1 : slices_q))
                     : (mode < 9) ? 9'($urandom) : slices_q;
      send_point(a, b);
    end
  endtask

  task automatic test_random_grid();
    int unsigned ph;
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      if (ph == 7)
        set_geometry(24'hFFFFFF, 24'h000001, 1, 1);
      else
        set_geometry($urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
                     $urandom_range(256, 0), $urandom_range(256, 0));
      run_random_phase(55);
      // Hold off until every vertex has come back
      if (ph == 3) drain_pipeline();
    end
  endtask

  initial begin
    radius_q = 24'd65536;
    height_q = 24'd65536;
    stacks_q = 9'd8;
    slices_q = 9'd16;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_points();
    test_random_grid();
    drain_pipeline();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
